### src/capture_date_time_parser_macros.svh
// Assertion macros for the date/time parser.
`ifndef CAPTURE_DATE_TIME_PARSER_MACROS_SVH
`define CAPTURE_DATE_TIME_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define CDTP_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("cdtp assertion failed");
// checked in and out of reset
`define CDTP_ASSERT_ANY(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("cdtp assertion failed");
`else
`define CDTP_ASSERT(lbl, clk_s, rstn_s, prop)
`define CDTP_ASSERT_ANY(lbl, clk_s, prop)
`endif
`endif

### src/cdtp_pkg.sv
// Shared types, constants and helper functions for the date/time parser.
package cdtp_pkg;

  typedef logic [4:0] pos_t;

  // byte positions within the text
  localparam pos_t P_YEAR0     = 5'd0;
  localparam pos_t P_YEAR1     = 5'd1;
  localparam pos_t P_YEAR2     = 5'd2;
  localparam pos_t P_YEAR3     = 5'd3;
  localparam pos_t P_SEP_DATE0 = 5'd4;
  localparam pos_t P_MON0      = 5'd5;
  localparam pos_t P_MON1      = 5'd6;
  localparam pos_t P_SEP_DATE1 = 5'd7;
  localparam pos_t P_DAY0      = 5'd8;
  localparam pos_t P_DAY1      = 5'd9;
  localparam pos_t P_SEP_TIME  = 5'd10;
  localparam pos_t P_HOUR0     = 5'd11;
  localparam pos_t P_HOUR1     = 5'd12;
  localparam pos_t P_COLON0    = 5'd13;
  localparam pos_t P_MIN0      = 5'd14;
  localparam pos_t P_MIN1      = 5'd15;
  localparam pos_t P_COLON1    = 5'd16;
  localparam pos_t P_SEC0      = 5'd17;
  localparam pos_t P_SEC1      = 5'd18;
  localparam pos_t POS_MAX     = 5'd31;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [6:0] MONTH_FEB  = 7'd2;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  year_hi;    // first two year digits, for the 400 rule
    logic        ylo_zero;   // last two year digits are both zero
    logic        form_error;
  } acc_t;

  typedef struct packed {
    logic        valid_res;
    logic        has_time;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } res_t;

  // acc * 10 + d, wrapped to the accumulator width
  function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
    return {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, d};
  endfunction

  function automatic logic [13:0] push14(input logic [13:0] acc, input logic [3:0] d);
    return {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, d};
  endfunction

  function automatic logic [4:0] days_in(input logic [6:0] m, input logic leap);
    logic [3:0] idx;
    idx = m[3:0] - 4'd1;
    if (m == MONTH_FEB && leap) begin
      return 5'd29;
    end else if (m >= 7'd1 && m <= MONTH_MAX) begin
      return MONTH_DAYS[idx];
    end else begin
      return 5'd31;
    end
  endfunction

endpackage

### src/capture_date_time_parser.sv
// Top level of the streaming date/time text parser.
// A final byte moves from the input register into the output register, whose contents drive out_*.
// Throughput: one input word per cycle; only a final byte waits on a stalled output.
// The input register feeds the digit accumulators and checker; results go to an output register.
// Reset (rst_n low, synchronous) clears the pipeline, position and all accumulators.
`include "capture_date_time_parser_macros.svh"

module capture_date_time_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [13:0] year, [17:14] month, [22:18] day,
                                  // [27:23] hour, [33:28] minute, [39:34] second
  output logic [1:0]  out_tuser   // [0] valid_res, [1] has_time
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // parse state
  cdtp_pkg::pos_t pos_r;
  cdtp_pkg::pos_t pos_nxt;
  cdtp_pkg::acc_t acc_r;
  cdtp_pkg::acc_t acc_nxt;

  // output register
  logic           out_valid_r;
  cdtp_pkg::res_t out_res_r;
  cdtp_pkg::res_t res;

  logic       in_fire;
  logic       out_free;
  logic       s1_fire;
  logic       is_dig;
  logic [3:0] digit;

  // A non-final byte never needs the output slot, so it always moves on.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  assign is_dig = (s1_char_r >= cdtp_pkg::CHAR_ZERO) && (s1_char_r <= cdtp_pkg::CHAR_NINE);
  assign digit  = s1_char_r[3:0];

  // Per-position digit gathering and separator checks.
  always_comb begin
    acc_nxt = acc_r;
    case (pos_r)
      cdtp_pkg::P_YEAR0, cdtp_pkg::P_YEAR1: begin
        if (is_dig) begin
          acc_nxt.year    = cdtp_pkg::push14(acc_r.year, digit);
          acc_nxt.year_hi = cdtp_pkg::push7(acc_r.year_hi, digit);
        end else begin
          acc_nxt.form_error = 1'b1;
        end
      end
      cdtp_pkg::P_YEAR2: begin
        if (is_dig) begin
          acc_nxt.year     = cdtp_pkg::push14(acc_r.year, digit);
          acc_nxt.ylo_zero = (digit == 4'd0);
        end else begin
          acc_nxt.form_error = 1'b1;
        end
      end
      cdtp_pkg::P_YEAR3: begin
        if (is_dig) begin
          acc_nxt.year     = cdtp_pkg::push14(acc_r.year, digit);
          acc_nxt.ylo_zero = acc_r.ylo_zero && (digit == 4'd0);
        end else begin
          acc_nxt.form_error = 1'b1;
        end
      end
      cdtp_pkg::P_MON0, cdtp_pkg::P_MON1: begin
        if (is_dig) acc_nxt.month = cdtp_pkg::push7(acc_r.month, digit);
        else acc_nxt.form_error = 1'b1;
      end
      cdtp_pkg::P_DAY0, cdtp_pkg::P_DAY1: begin
        if (is_dig) acc_nxt.day = cdtp_pkg::push7(acc_r.day, digit);
        else acc_nxt.form_error = 1'b1;
      end
      cdtp_pkg::P_HOUR0, cdtp_pkg::P_HOUR1: begin
        if (is_dig) acc_nxt.hour = cdtp_pkg::push7(acc_r.hour, digit);
        else acc_nxt.form_error = 1'b1;
      end
      cdtp_pkg::P_MIN0, cdtp_pkg::P_MIN1: begin
        if (is_dig) acc_nxt.minute = cdtp_pkg::push7(acc_r.minute, digit);
        else acc_nxt.form_error = 1'b1;
      end
      cdtp_pkg::P_SEC0, cdtp_pkg::P_SEC1: begin
        if (is_dig) acc_nxt.second = cdtp_pkg::push7(acc_r.second, digit);
        else acc_nxt.form_error = 1'b1;
      end
      cdtp_pkg::P_SEP_DATE0, cdtp_pkg::P_SEP_DATE1, cdtp_pkg::P_SEP_TIME: begin
        if (is_dig) acc_nxt.form_error = 1'b1;
      end
      cdtp_pkg::P_COLON0, cdtp_pkg::P_COLON1: begin
        if (s1_char_r != cdtp_pkg::CHAR_COLON) acc_nxt.form_error = 1'b1;
      end
      default: begin
        // past the seconds: counted, not parsed
      end
    endcase
  end

  // saturating byte count
  assign pos_nxt = (pos_r == cdtp_pkg::POS_MAX) ? pos_r : pos_r + 5'd1;

  // text ends: state goes back to its reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        pos_r <= '0;
        acc_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

  cdtp_eval u_eval (
    .acc (acc_nxt),
    .pos (pos_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.has_time, out_res_r.valid_res};
  assign out_tdata  = {out_res_r.second, out_res_r.minute, out_res_r.hour,
                       out_res_r.day, out_res_r.month, out_res_r.year};

  `CDTP_ASSERT_ANY(a_rst_clears_out, clk, !rst_n |=> !out_tvalid && !s1_valid_r)
  `CDTP_ASSERT(a_last_clears_pos, clk, rst_n, s1_fire && s1_last_r |=> pos_r == '0)
  `CDTP_ASSERT(a_byte_advances_pos, clk, rst_n, s1_fire && !s1_last_r |=> pos_r != '0)
  `CDTP_ASSERT(a_time_needs_valid, clk, rst_n, out_tvalid && out_tuser[1] |-> out_tuser[0])
  `CDTP_ASSERT(a_invalid_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata == '0)
  `CDTP_ASSERT(a_month_range, clk, rst_n,
    out_tvalid && out_tuser[0] |-> out_tdata[17:14] != 4'd0 && out_tdata[17:14] <= 4'd12)

endmodule

### src/cdtp_eval.sv
// Final check of the gathered fields on the last byte of a text.
module cdtp_eval (
  input  cdtp_pkg::acc_t acc,   // accumulators including the last byte
  input  cdtp_pkg::pos_t pos,   // position of the last byte
  output cdtp_pkg::res_t res
);

  logic       len_date;
  logic       timed;
  logic       leap;
  logic [4:0] max_day;
  logic       date_ok;
  logic       time_ok;
  logic       ok;

  // year % 4 is the low two bits of the binary year; a century year checks its first two digits
  assign leap = acc.ylo_zero ? (acc.year_hi[1:0] == 2'b00)
                             : (acc.year[1:0] == 2'b00);
  assign max_day  = cdtp_pkg::days_in(acc.month, leap);
  assign len_date = (pos == cdtp_pkg::P_DAY1);
  assign timed    = (pos >= cdtp_pkg::P_SEC1);

  assign date_ok = (acc.year != 14'd0) && (acc.month >= 7'd1) &&
                   (acc.month <= cdtp_pkg::MONTH_MAX) && (acc.day >= 7'd1) &&
                   (acc.day <= {2'b00, max_day});
  assign time_ok = (acc.hour <= cdtp_pkg::HOUR_MAX) &&
                   (acc.minute <= cdtp_pkg::MINSEC_MAX) &&
                   (acc.second <= cdtp_pkg::MINSEC_MAX);
  assign ok = !acc.form_error && (len_date || timed) && date_ok && (!timed || time_ok);

  always_comb begin
    res = '0;
    if (ok) begin
      res.valid_res = 1'b1;
      res.has_time  = timed;
      res.year      = acc.year;
      res.month     = acc.month[3:0];
      res.day       = acc.day[4:0];
      if (timed) begin
        res.hour   = acc.hour[4:0];
        res.minute = acc.minute[5:0];
        res.second = acc.second[5:0];
      end
    end
  end

endmodule
